>>> src/aqs_pkg.sv
`timescale 1ns / 1ps

package aqs_pkg;

    localparam int LBA_W  = 28;
    localparam int WORD_W = 16;
    localparam int TMO_W  = 16;
    localparam int IDX_W  = 8;

    // Input word kinds.
    localparam logic [1:0] KIND_SUBMIT = 2'd0;
    localparam logic [1:0] KIND_IRQ    = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_DATA   = 2'd3;

    // Result word kinds.
    localparam logic [1:0] OUT_REG_WRITE = 2'd0;
    localparam logic [1:0] OUT_READ_WORD = 2'd1;
    localparam logic [1:0] OUT_DONE      = 2'd2;
    localparam logic [1:0] OUT_REJECT    = 2'd3;

    // Task-file register offsets from the primary base port 0x1F0.
    localparam logic [2:0] OFS_SECT_COUNT = 3'd2;
    localparam logic [2:0] OFS_LBA_LOW    = 3'd3;
    localparam logic [2:0] OFS_LBA_MID    = 3'd4;
    localparam logic [2:0] OFS_LBA_HIGH   = 3'd5;
    localparam logic [2:0] OFS_DRIVE_HEAD = 3'd6;
    localparam logic [2:0] OFS_COMMAND    = 3'd7;

    localparam logic [7:0] DRIVE_LBA_MASTER = 8'hE0;
    localparam logic [7:0] ONE_SECTOR       = 8'h01;
    localparam logic [7:0] CMD_READ_PIO     = 8'h20;
    localparam logic [7:0] CMD_WRITE_PIO    = 8'h30;

    // Index of the final word of a 256-word sector.
    localparam logic [IDX_W-1:0] SECTOR_LAST = 8'hFF;

    localparam logic [TMO_W-1:0] TMO_RESET = 16'd5000;

    // Command burst: six register writes, steps 0 to 5.
    localparam logic [2:0] STEP_LAST = 3'd5;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_write;
        logic [LBA_W-1:0]  lba;
        logic [WORD_W-1:0] data_word;
    } req_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [2:0]        reg_offset;
        logic [7:0]        reg_value;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] read_data;
        logic              success;
        logic [LBA_W-1:0]  done_lba;
        logic              busy_res;
        logic              last;
    } res_t;

    typedef struct packed {
        logic       push;
        logic       fetch;
        logic       load;
        logic       drain_start;
        logic       tick_dec;
        logic       word_inc;
        logic       finish;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_ok;
        logic       out_last;
        logic       out_busy;
        logic [2:0] reg_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic full;
        logic queued;
        logic active;
        logic active_is_write;
        logic draining;
        logic tmo_zero;
        logic tmo_one;
        logic sector_end;
        logic out_free;
    } ctl_stat_t;

    // Offset and value of one register write of the command burst.
    function automatic logic [10:0] reg_write(input logic [2:0] step,
                                              input logic [LBA_W-1:0] lba,
                                              input logic is_write);
        logic [10:0] r;
        unique case (step)
            3'd0:    r = {OFS_DRIVE_HEAD, DRIVE_LBA_MASTER | {4'h0, lba[27:24]}};
            3'd1:    r = {OFS_SECT_COUNT, ONE_SECTOR};
            3'd2:    r = {OFS_LBA_LOW, lba[7:0]};
            3'd3:    r = {OFS_LBA_MID, lba[15:8]};
            3'd4:    r = {OFS_LBA_HIGH, lba[23:16]};
            3'd5:    r = {OFS_COMMAND, is_write ? CMD_WRITE_PIO : CMD_READ_PIO};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/aqs_ram.sv
`timescale 1ns / 1ps

module aqs_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/aqs_datapath.sv
`timescale 1ns / 1ps

module aqs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  aqs_pkg::req_t             s_payload,
    input  logic                      cfg_valid,
    input  logic [aqs_pkg::TMO_W-1:0] cfg_data,
    input  aqs_pkg::ctl_cmd_t         cmd,
    output aqs_pkg::ctl_stat_t        stat,
    input  logic                      m_ready,
    output logic                      m_valid,
    output aqs_pkg::res_t             m_payload
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW  = aqs_pkg::LBA_W + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          active_reg, active_next;
    logic          is_write_reg, is_write_next;
    logic [aqs_pkg::LBA_W-1:0] lba_reg, lba_next;
    logic [aqs_pkg::TMO_W-1:0] tmo_left_reg, tmo_left_next;
    logic [aqs_pkg::TMO_W-1:0] tmo_ticks_reg, tmo_ticks_next;
    logic          draining_reg, draining_next;
    logic [aqs_pkg::IDX_W-1:0] words_reg, words_next;
    logic          m_valid_reg, m_valid_next;
    aqs_pkg::res_t m_payload_reg, m_payload_next;
    logic [EW-1:0] rd_entry;
    logic [10:0]   rw;

    aqs_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data ({s_payload.is_write, s_payload.lba}),
        .rd_en   (cmd.fetch),
        .rd_addr (head_reg),
        .rd_data (rd_entry)
    );

    always_comb begin
        stat.full            = (count_reg == CW'(QUEUE_DEPTH));
        stat.queued          = (count_reg != '0);
        stat.active          = active_reg;
        stat.active_is_write = is_write_reg;
        stat.draining        = draining_reg;
        stat.tmo_zero        = (tmo_left_reg == '0);
        stat.tmo_one         = (tmo_left_reg == aqs_pkg::TMO_W'(1));
        stat.sector_end      = (words_reg == aqs_pkg::SECTOR_LAST);
        stat.out_free        = !m_valid_reg || m_ready;
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        is_write_next  = is_write_reg;
        lba_next       = lba_reg;
        tmo_left_next  = tmo_left_reg;
        tmo_ticks_next = tmo_ticks_reg;
        draining_next  = draining_reg;
        words_next     = words_reg;

        if (cfg_valid) begin
            tmo_ticks_next = cfg_data;
        end
        if (cmd.push) begin
            tail_next  = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end
        if (cmd.load) begin
            head_next     = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next    = count_reg - CW'(1);
            active_next   = 1'b1;
            is_write_next = rd_entry[EW-1];
            lba_next      = rd_entry[aqs_pkg::LBA_W-1:0];
            tmo_left_next = tmo_ticks_reg;
            draining_next = 1'b0;
            words_next    = '0;
        end
        if (cmd.drain_start) begin
            draining_next = 1'b1;
            words_next    = '0;
        end
        if (cmd.tick_dec) begin
            tmo_left_next = tmo_left_reg - aqs_pkg::TMO_W'(1);
        end
        if (cmd.word_inc) begin
            words_next = words_reg + aqs_pkg::IDX_W'(1);
        end
        if (cmd.finish) begin
            active_next   = 1'b0;
            draining_next = 1'b0;
            words_next    = '0;
            tmo_left_next = '0;
        end
    end

    // Result word assembly; done_lba, busy_res and last are set for every kind, other unused fields stay zero.
    always_comb begin
        rw             = aqs_pkg::reg_write(cmd.reg_step, lba_reg, is_write_reg);
        m_payload_next = '0;
        m_payload_next.out_kind = cmd.out_kind;
        m_payload_next.busy_res = cmd.out_busy;
        m_payload_next.last     = cmd.out_last;
        m_payload_next.done_lba = lba_reg;
        unique case (cmd.out_kind)
            aqs_pkg::OUT_REG_WRITE: begin
                m_payload_next.reg_offset = rw[10:8];
                m_payload_next.reg_value  = rw[7:0];
            end
            aqs_pkg::OUT_READ_WORD: begin
                m_payload_next.word_index = words_reg;
                m_payload_next.read_data  = s_payload.data_word;
            end
            aqs_pkg::OUT_DONE: begin
                m_payload_next.success = cmd.out_ok;
                // A completion while draining carries the final word of the sector.
                if (draining_reg) begin
                    m_payload_next.word_index = words_reg;
                    m_payload_next.read_data  = s_payload.data_word;
                end
            end
            aqs_pkg::OUT_REJECT: begin
                m_payload_next.done_lba = s_payload.lba;
            end
            default: begin
                m_payload_next = '0;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= 1'b0;
            is_write_reg  <= 1'b0;
            lba_reg       <= '0;
            tmo_left_reg  <= '0;
            tmo_ticks_reg <= aqs_pkg::TMO_RESET;
            draining_reg  <= 1'b0;
            words_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            is_write_reg  <= is_write_next;
            lba_reg       <= lba_next;
            tmo_left_reg  <= tmo_left_next;
            tmo_ticks_reg <= tmo_ticks_next;
            draining_reg  <= draining_next;
            words_reg     <= words_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> src/aqs_ctrl.sv
`timescale 1ns / 1ps

module aqs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         s_kind,
    output logic               s_ready,
    input  aqs_pkg::ctl_stat_t stat,
    output aqs_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } seq_state_t;

    seq_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       take;
    logic       complete;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        take       = 1'b0;
        complete   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = stat.out_free;
                take    = s_valid && stat.out_free;
                if (take) begin
                    unique case (s_kind)
                        aqs_pkg::KIND_SUBMIT: begin
                            if (stat.full) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = aqs_pkg::OUT_REJECT;
                                cmd.out_busy = 1'b1;
                                cmd.out_last = 1'b1;
                            end else begin
                                cmd.push = 1'b1;
                                if (!stat.active) begin
                                    state_next = ST_FETCH;
                                end
                            end
                        end
                        aqs_pkg::KIND_IRQ: begin
                            if (stat.active && !stat.draining) begin
                                if (stat.active_is_write) begin
                                    complete   = 1'b1;
                                    cmd.out_ok = 1'b1;
                                end else begin
                                    cmd.drain_start = 1'b1;
                                end
                            end
                        end
                        aqs_pkg::KIND_TICK: begin
                            if (stat.active && !stat.draining && !stat.tmo_zero) begin
                                cmd.tick_dec = 1'b1;
                                complete     = stat.tmo_one;
                            end
                        end
                        aqs_pkg::KIND_DATA: begin
                            if (stat.active && stat.draining) begin
                                if (stat.sector_end) begin
                                    complete   = 1'b1;
                                    cmd.out_ok = 1'b1;
                                end else begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = aqs_pkg::OUT_READ_WORD;
                                    cmd.out_busy = 1'b1;
                                    cmd.out_last = 1'b1;
                                    cmd.word_inc = 1'b1;
                                end
                            end
                        end
                        default: begin
                            cmd = '0;
                        end
                    endcase
                end
                // A completion starts the next queued request, if any.
                if (complete) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = aqs_pkg::OUT_DONE;
                    cmd.out_busy = stat.queued;
                    cmd.out_last = !stat.queued;
                    cmd.finish   = 1'b1;
                    if (stat.queued) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = aqs_pkg::OUT_REG_WRITE;
                    cmd.out_busy = 1'b1;
                    cmd.reg_step = step_reg;
                    cmd.out_last = (step_reg == aqs_pkg::STEP_LAST);
                    if (step_reg == aqs_pkg::STEP_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> src/ata_pio_queued_command_sequencer_unit.sv
`timescale 1ns / 1ps

// Channel    Ports                           Word
// input      s_valid s_ready s_payload       aqs_pkg::req_t
// result     m_valid m_ready m_payload       aqs_pkg::res_t
// config     cfg_valid cfg_ready cfg_data    timeout tick count
//
// A word that yields at most one result (interrupt, tick, data word, queued or
// rejected submit) is handled in ST_IDLE, which takes the next word once the output register is free.
// A word that starts a request holds the input through one queue RAM read,
// one load, then six task-file writes through the single output register.
// Reset (aresetn low) clears all control state; the queue RAM is not cleared.
// A stalled m_ready holds the output register and, through it, the input side.

module ata_pio_queued_command_sequencer_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  aqs_pkg::req_t             s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output aqs_pkg::res_t             m_payload,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [aqs_pkg::TMO_W-1:0] cfg_data
);

    aqs_pkg::ctl_cmd_t  cmd;
    aqs_pkg::ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    aqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_payload.kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    aqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

endmodule
